// File: design/random_free_slot_allocator_assert.svh
// assertion macros used by the checker file of the slot allocator
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef RANDOM_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define RANDOM_FREE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, reset masks the check
`define RFSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define RFSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rfsa_pkg.sv
// shared constants and word types of the random free slot allocator
// no dependencies; used by the top level and its checker
`default_nettype none

package rfsa_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int RND_W      = 16;
    localparam int IDX_W      = 5;
    localparam int GRANT_W    = 6;

    // free slot count and remainder width, and dividend bit counter width
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int RND_CNT_W  = $clog2(RND_W);

    // map scan goes one digit of slots per cycle
    localparam int DIGIT_W    = 8;
    localparam int POS_W      = $clog2(DIGIT_W);
    localparam int ZCNT_W     = $clog2(DIGIT_W + 1);
    localparam int NDIG       = (SLOT_COUNT + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int SEL_W      = DIG_CNT_W + POS_W;
    localparam int SCAN_W     = NDIG * DIGIT_W;
    localparam int KW         = (CNT_W > ZCNT_W) ? CNT_W : ZCNT_W;

    // padding slots past the end read as taken
    localparam logic [SCAN_W-1:0] PAD_MASK  = ~SCAN_W'({SLOT_COUNT{1'b1}});
    localparam logic [SCAN_W-1:0] FILL_MASK = ~({SCAN_W{1'b1}} >> DIGIT_W);

    localparam logic [GRANT_W-1:0] NONE_CODE = GRANT_W'(SLOT_COUNT);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [RND_W-1:0]   random_value;
        logic [IDX_W-1:0]   slot_index;
    } t_in_word;

    typedef struct packed {
        logic [GRANT_W-1:0] granted_slot;
        logic               slot_taken;
        logic               all_taken;
    } t_out_word;

endpackage

`default_nettype wire

// File: design/random_free_slot_allocator.sv
// Random free slot allocator. Keeps a map of taken slots (all free after reset) and a
// running free count. An allocate word takes random_value modulo the free count in a
// bit-serial restoring divider, one dividend bit per cycle, then scans the map one
// 8-slot digit per cycle for the k-th free slot, claims it and reports its index. A
// test word reports whether one slot is taken. An allocate word passes through the
// divide, scan and emit states; a test word, or an allocate word with no free slot,
// goes straight to emit, which waits while an untaken result holds the output. One
// word is worked on at a time; the output register lets the next word in while a
// result waits to be taken. Depends on rfsa_pkg.
`default_nettype none

module random_free_slot_allocator (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  rfsa_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output rfsa_pkg::t_out_word  o_out_word
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                               r_state, n_state;
    logic [rfsa_pkg::SLOT_COUNT-1:0]      r_mask, n_mask;
    logic [rfsa_pkg::CNT_W-1:0]           r_free, n_free;
    logic [rfsa_pkg::RND_W-1:0]           r_rnd, n_rnd;
    logic [rfsa_pkg::RND_CNT_W-1:0]       r_bit, n_bit;
    logic [rfsa_pkg::CNT_W-1:0]           r_rem, n_rem;
    logic [rfsa_pkg::SCAN_W-1:0]          r_scan, n_scan;
    logic [rfsa_pkg::DIG_CNT_W-1:0]       r_dig, n_dig;
    logic [rfsa_pkg::GRANT_W-1:0]         r_res_grant, n_res_grant;
    logic                                 r_res_taken, n_res_taken;
    logic                                 r_out_valid, n_out_valid;
    rfsa_pkg::t_out_word                  r_out_word, n_out_word;

    logic                                 in_acc;
    logic [rfsa_pkg::CNT_W:0]             trial;
    logic [rfsa_pkg::DIGIT_W-1:0]         digit;
    logic [rfsa_pkg::ZCNT_W-1:0]          zeros;
    logic [rfsa_pkg::ZCNT_W-1:0]          seen;
    logic [rfsa_pkg::POS_W-1:0]           pos;
    logic                                 found;
    logic [rfsa_pkg::KW-1:0]              kx;
    logic [rfsa_pkg::SEL_W-1:0]           sel;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // one restoring division step
    assign trial = {r_rem, r_rnd[rfsa_pkg::RND_W-1]};

    // free slots in the current digit and the place of the k-th one
    assign digit = r_scan[rfsa_pkg::DIGIT_W-1:0];
    assign kx    = rfsa_pkg::KW'(r_rem);
    assign sel   = {r_dig, pos};

    always_comb begin
        zeros = '0;
        seen  = '0;
        pos   = '0;
        found = 1'b0;
        for (int i = 0; i < rfsa_pkg::DIGIT_W; i++) begin
            if (!digit[i]) begin
                if (!found && seen == rfsa_pkg::ZCNT_W'(r_rem)) begin
                    pos   = rfsa_pkg::POS_W'(i);
                    found = 1'b1;
                end
                seen  = seen + 1'b1;
                zeros = zeros + 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_free      = r_free;
        n_rnd       = r_rnd;
        n_bit       = r_bit;
        n_rem       = r_rem;
        n_scan      = r_scan;
        n_dig       = r_dig;
        n_res_grant = r_res_grant;
        n_res_taken = r_res_taken;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_grant = rfsa_pkg::NONE_CODE;
                    n_res_taken = 1'b0;
                    if (i_in_word.mode == rfsa_pkg::MODE_TEST) begin
                        // shifted-out one means the slot does not exist
                        n_res_taken = |(r_mask & (rfsa_pkg::SLOT_COUNT'(1)
                                                  << i_in_word.slot_index));
                        n_state     = ST_EMIT;
                    end else if (r_free == '0) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_rnd   = i_in_word.random_value;
                        n_rem   = '0;
                        n_bit   = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_free}) begin
                    n_rem = rfsa_pkg::CNT_W'(trial - {1'b0, r_free});
                end else begin
                    n_rem = rfsa_pkg::CNT_W'(trial);
                end
                n_rnd = r_rnd << 1;
                n_bit = r_bit + 1'b1;
                if (r_bit == rfsa_pkg::RND_CNT_W'(rfsa_pkg::RND_W - 1)) begin
                    n_scan  = rfsa_pkg::SCAN_W'(r_mask) | rfsa_pkg::PAD_MASK;
                    n_dig   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (kx < rfsa_pkg::KW'(zeros)) begin
                    n_mask      = r_mask | (rfsa_pkg::SLOT_COUNT'(1) << sel);
                    n_free      = r_free - 1'b1;
                    n_res_grant = rfsa_pkg::GRANT_W'(sel);
                    n_state     = ST_EMIT;
                end else begin
                    n_rem  = rfsa_pkg::CNT_W'(kx - rfsa_pkg::KW'(zeros));
                    n_scan = (r_scan >> rfsa_pkg::DIGIT_W) | rfsa_pkg::FILL_MASK;
                    n_dig  = r_dig + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_word.granted_slot = r_res_grant;
                    n_out_word.slot_taken   = r_res_taken;
                    n_out_word.all_taken    = (r_free == '0);
                    n_out_valid             = 1'b1;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mask      <= '0;
            r_free      <= rfsa_pkg::CNT_W'(rfsa_pkg::SLOT_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd       <= n_rnd;
        r_bit       <= n_bit;
        r_rem       <= n_rem;
        r_scan      <= n_scan;
        r_dig       <= n_dig;
        r_res_grant <= n_res_grant;
        r_res_taken <= n_res_taken;
        r_out_word  <= n_out_word;
    end

endmodule

`default_nettype wire

// File: design/rfsa_checker.sv
// port-level checks of the random free slot allocator and the bind that attaches them
// depends on rfsa_pkg and random_free_slot_allocator_assert.svh
`default_nettype none

`include "random_free_slot_allocator_assert.svh"

module rfsa_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  rfsa_pkg::t_in_word   i_in_word,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  rfsa_pkg::t_out_word  i_out_word
);

    logic [1:0] r_cnt, n_cnt;
    logic       r_full, n_full;
    logic       in_acc;
    logic       out_acc;
    logic       unused_in;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_acc   = i_out_valid && i_out_ready;
    assign unused_in = ^i_in_word;

    // words taken in but not yet delivered
    always_comb begin
        n_cnt  = r_cnt + {1'b0, in_acc} - {1'b0, out_acc};
        n_full = r_full || (out_acc && i_out_word.all_taken);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_full <= n_full;
        end
    end

    `RFSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "result word dropped or changed while stalled")

    `RFSA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in_ready, "new word taken in the cycle after an accept")

    `RFSA_ASSERT_IMP(a_no_invented, i_clk, i_rst_n, i_out_valid, r_cnt != 2'd0 || unused_in != unused_in, "result word with no word taken in")

    `RFSA_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, in_acc, r_cnt != 2'd2, "more than one word behind the output register")

    `RFSA_ASSERT_IMP(a_full_stays, i_clk, i_rst_n, i_out_valid && r_full, i_out_word.all_taken && i_out_word.granted_slot == rfsa_pkg::NONE_CODE, "slot granted after the map was full")

endmodule

bind random_free_slot_allocator rfsa_checker u_rfsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for random_free_slot_allocator: directed table then random words
// keeps its own copy of the taken-slot map to predict each result; depends on rfsa_pkg
`default_nettype none

module testbench;

    import rfsa_pkg::*;

    typedef struct {
        t_in_word  word;
        bit        has_exp;
        t_out_word exp;
    } stim_row_t;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    logic [SLOT_COUNT-1:0] taken_map = '0;
    t_out_word             expected_grants[$];
    stim_row_t             directed_rows[$];
    int unsigned           mismatches = 0;

    random_free_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // advances the local slot map by one word and returns the result it causes
    function automatic t_out_word slot_map_step(input t_in_word w);
        t_out_word   r;
        int unsigned free_cnt;
        int unsigned k;
        r.granted_slot = NONE_CODE;
        r.slot_taken   = 1'b0;
        if (w.mode == MODE_ALLOC) begin
            free_cnt = SLOT_COUNT - $countones(taken_map);
            if (free_cnt != 0) begin
                k = w.random_value % free_cnt;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!taken_map[i]) begin
                        if (k == 0) begin
                            taken_map[i]   = 1'b1;
                            r.granted_slot = GRANT_W'(i);
                            break;
                        end
                        k--;
                    end
                end
            end
        end else begin
            r.slot_taken = taken_map[w.slot_index];
        end
        r.all_taken = &taken_map;
        return r;
    endfunction

    function automatic stim_row_t make_row(input logic mode, input logic [RND_W-1:0] rnd,
                                           input logic [IDX_W-1:0] idx, input bit has_exp,
                                           input logic [GRANT_W-1:0] gs, input logic st,
                                           input logic at);
        stim_row_t row;
        row.word.mode             = mode;
        row.word.random_value     = rnd;
        row.word.slot_index       = idx;
        row.has_exp               = has_exp;
        row.exp.granted_slot      = gs;
        row.exp.slot_taken        = st;
        row.exp.all_taken         = at;
        return row;
    endfunction

    // drain holds the sender off until every outstanding result has come back
    task automatic send_word(input t_in_word w, input bit has_exp, input t_out_word exp,
                             input int unsigned gap, input bit drain);
        t_out_word predicted;
        if (gap > 0 || drain) begin
            i_in_valid <= 1'b0;
            if (drain) begin
                do @(posedge i_clk); while (expected_grants.size() != 0);
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = slot_map_step(w);
        expected_grants.push_back(has_exp ? exp : predicted);
    endtask

    // result side: bursts of ready with stalls of random length between them
    initial begin
        int unsigned run;
        int unsigned gap;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_grants.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word %h", $time, o_out_word);
            end else begin
                want = expected_grants.pop_front();
                if (o_out_word.granted_slot !== want.granted_slot) begin
                    mismatches++;
                    $display("%0t: granted_slot expected %0d got %0d", $time,
                             want.granted_slot, o_out_word.granted_slot);
                end
                if (o_out_word.slot_taken !== want.slot_taken) begin
                    mismatches++;
                    $display("%0t: slot_taken expected %0b got %0b", $time,
                             want.slot_taken, o_out_word.slot_taken);
                end
                if (o_out_word.all_taken !== want.all_taken) begin
                    mismatches++;
                    $display("%0t: all_taken expected %0b got %0b", $time,
                             want.all_taken, o_out_word.all_taken);
                end
            end
        end
    end

    initial begin
        t_in_word    w;
        t_out_word   none_exp;
        int unsigned free_cnt;
        int unsigned sel;
        bit          calm;

        none_exp = '0;
        // empty map, lowest and highest slot, random extremes, both modes
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'd0,  1, NONE_CODE, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'hFFFF, 5'd31, 1, NONE_CODE, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h0000, 5'd31, 1, 6'd0,      0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'd0,  1, NONE_CODE, 1, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h0000, 5'd0,  1, 6'd1,      0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'd1,  1, NONE_CODE, 1, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'hFFFF, 5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h8000, 5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h0001, 5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h7FFF, 5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'd31, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'hFFFF, 5'd17, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'h15, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'hAAAA, 5'h0A, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'h5555, 5'h15, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'h0A, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_TEST,  16'h0000, 5'h1F, 0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'd25,   5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'hFFFE, 5'd0,  0, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_ALLOC, 16'd23,   5'd0,  0, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            send_word(directed_rows[n].word, directed_rows[n].has_exp,
                      directed_rows[n].exp, pick_gap(), 1'b0);

        for (int n = 0; n < 900; n++) begin
            // a stretch of back-to-back words in the middle of the run
            calm = (n >= 400 && n < 550);
            free_cnt = SLOT_COUNT - $countones(taken_map);
            w.mode = (free_cnt != 0) ? (($urandom_range(0, 9) < 6) ? MODE_ALLOC : MODE_TEST)
                                     : logic'($urandom_range(0, 1));
            sel = $urandom_range(0, 7);
            case (sel)
                0: w.random_value = '0;
                1: w.random_value = '1;
                2: w.random_value = RND_W'(free_cnt == 0 ? 0 : free_cnt - 1);
                3: w.random_value = RND_W'(free_cnt);
                default: w.random_value = RND_W'($urandom);
            endcase
            w.slot_index = IDX_W'($urandom);
            send_word(w, 1'b0, none_exp, calm ? 0 : pick_gap(),
                      (n == 300) || ($urandom_range(0, 99) == 0));
        end
        i_in_valid <= 1'b0;

        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
